// ===== rtl/jfs_pkg.sv =====
`default_nettype none

package jfs_pkg;

  typedef enum logic [2:0] {
    PH_SOI0  = 3'd0,
    PH_SOI1  = 3'd1,
    PH_HUNT  = 3'd2,
    PH_MARK  = 3'd3,
    PH_LENHI = 3'd4,
    PH_LENLO = 3'd5,
    PH_BODY  = 3'd6,
    PH_DONE  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOSOI     = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  localparam logic [7:0] MarkPrefix = 8'hff;
  localparam logic [7:0] MarkSoi    = 8'hd8;
  localparam logic [7:0] MarkEoi    = 8'hd9;
  localparam logic [7:0] MarkSos    = 8'hda;
  localparam logic [7:0] MarkTem    = 8'h01;
  localparam logic [7:0] MarkRst0   = 8'hd0;
  localparam logic [7:0] MarkNone   = 8'h00;

  localparam logic [15:0] MinSegLen   = 16'd2;
  localparam logic [15:0] MinFrameLen = 16'd7;

  typedef struct packed {
    status_e     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        keep_image;
  } result_t;

  // sof0..sof15, leaving out dht (c4), jpg (c8) and dac (cc)
  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m[7:4] == 4'hc) && (m[3:0] != 4'h4) && (m[3:0] != 4'h8) &&
           (m[3:0] != 4'hc);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jfs_parser.sv =====
`default_nettype none

module jfs_parser import jfs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        beat_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output result_t          res_o,
  output logic             res_valid_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] remain_q, remain_d;
  logic [2:0]  offset_q, offset_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        found_q, found_d;
  logic        in_frame_q, in_frame_d;
  logic        mode_q;

  logic        give;
  status_e     give_status;
  logic [15:0] seg_len;
  logic [15:0] remain_dec;
  logic        restart_mark;

  assign seg_len      = {len_hi_q, data_byte_i};
  assign remain_dec   = remain_q - 16'd1;
  assign restart_mark = (data_byte_i == MarkNone) || (data_byte_i == MarkTem) ||
                        ((data_byte_i >= MarkRst0) && (data_byte_i <= MarkSoi));

  // which beats finish the file with a result, and with what status
  always_comb begin
    give        = 1'b0;
    give_status = ST_TRUNC;
    case (phase_q)
      PH_SOI0: begin
        if (data_byte_i != MarkPrefix || end_of_file_i) begin
          give        = 1'b1;
          give_status = ST_NOSOI;
        end
      end
      PH_SOI1: begin
        if (data_byte_i != MarkSoi) begin
          give        = 1'b1;
          give_status = ST_NOSOI;
        end
      end
      PH_MARK: begin
        if (data_byte_i == MarkEoi) begin
          give        = 1'b1;
          give_status = found_q ? ST_OK : ST_TRUNC;
        end else if (data_byte_i == MarkSos && found_q) begin
          give        = 1'b1;
          give_status = ST_OK;
        end
      end
      PH_LENLO: begin
        if (seg_len < MinSegLen || (in_frame_q && seg_len < MinFrameLen)) begin
          give        = 1'b1;
          give_status = ST_MALFORMED;
        end
      end
      default: ;
    endcase
    // end of file with nothing given yet
    if (!give && end_of_file_i && phase_q != PH_DONE) begin
      give        = 1'b1;
      give_status = ST_TRUNC;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    remain_d   = remain_q;
    offset_d   = offset_q;
    len_hi_d   = len_hi_q;
    width_d    = width_q;
    height_d   = height_q;
    found_d    = found_q;
    in_frame_d = in_frame_q;
    case (phase_q)
      PH_SOI0:  phase_d = PH_SOI1;
      PH_SOI1:  phase_d = PH_HUNT;
      PH_HUNT: begin
        if (data_byte_i == MarkPrefix) phase_d = PH_MARK;
      end
      PH_MARK: begin
        if (data_byte_i == MarkPrefix) begin
          phase_d = PH_MARK;
        end else if (restart_mark) begin
          phase_d = PH_HUNT;
        end else begin
          in_frame_d = !found_q && is_frame_marker(data_byte_i);
          phase_d    = PH_LENHI;
        end
      end
      PH_LENHI: begin
        len_hi_d = data_byte_i;
        phase_d  = PH_LENLO;
      end
      PH_LENLO: begin
        remain_d = seg_len - MinSegLen;
        offset_d = 3'd0;
        phase_d  = (seg_len == MinSegLen) ? PH_HUNT : PH_BODY;
      end
      PH_BODY: begin
        if (in_frame_q) begin
          case (offset_q)
            3'd1: height_d[15:8] = data_byte_i;
            3'd2: height_d[7:0]  = data_byte_i;
            3'd3: width_d[15:8]  = data_byte_i;
            3'd4: begin
              width_d[7:0] = data_byte_i;
              found_d      = 1'b1;
              in_frame_d   = 1'b0;
            end
            default: ;
          endcase
          offset_d = offset_q + 3'd1;
        end
        remain_d = remain_dec;
        if (remain_dec == 16'd0) phase_d = PH_HUNT;
      end
      default: ;
    endcase
    if (give) phase_d = PH_DONE;
    if (end_of_file_i) begin
      phase_d    = PH_SOI0;
      remain_d   = '0;
      offset_d   = '0;
      len_hi_d   = '0;
      width_d    = '0;
      height_d   = '0;
      found_d    = 1'b0;
      in_frame_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_o         = beat_i && give;
    res_o.status        = give_status;
    res_o.image_width   = '0;
    res_o.image_height  = '0;
    res_o.keep_image    = 1'b0;
    if (give_status == ST_OK) begin
      res_o.image_width  = width_q;
      res_o.image_height = height_q;
      res_o.keep_image   = mode_q ? (width_q < height_q) : (width_q > height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SOI0;
      remain_q   <= '0;
      offset_q   <= '0;
      len_hi_q   <= '0;
      width_q    <= '0;
      height_q   <= '0;
      found_q    <= 1'b0;
      in_frame_q <= 1'b0;
    end else if (beat_i) begin
      phase_q    <= phase_d;
      remain_q   <= remain_d;
      offset_q   <= offset_d;
      len_hi_q   <= len_hi_d;
      width_q    <= width_d;
      height_q   <= height_d;
      found_q    <= found_d;
      in_frame_q <= in_frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jfs_out_buf.sv =====
`default_nettype none

module jfs_out_buf import jfs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  result_t   push_data_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output result_t   data_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jpeg_frame_size_scanner_top.sv =====
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+-------------------------------------
// input    | in        | in_valid_i / in_ready_o    | data_byte_i, end_of_file_i
// result   | out       | out_valid_o / out_ready_i  | status_o, image_width_o,
//          |           |                            | image_height_o, keep_image_o
// config   | in        | cfg_we_i (no wait)         | cfg_wdata_i (orientation mode)
//
// one byte per cycle while in_ready_o is high: each beat updates the parser registers
// and any result lands in a two-entry output buffer on the same edge
// a result is registered: it never shows in the same cycle as the byte that causes it
// in_ready_o drops only while both buffer entries hold untaken results
// after reset the parser expects the soi marker as the first bytes; mode resets to wider-than-tall
`default_nettype none

module jpeg_frame_size_scanner_top import jfs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      image_width_o,
  output logic [15:0]      image_height_o,
  output logic             keep_image_o
);

  logic    beat;
  logic    buf_full;
  logic    res_valid;
  result_t res;
  result_t head;

  assign in_ready_o = !buf_full;
  assign beat       = in_valid_i && in_ready_o;

  jfs_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .beat_i        (beat),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .res_o         (res),
    .res_valid_o   (res_valid)
  );

  jfs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (head)
  );

  assign status_o       = head.status;
  assign image_width_o  = head.image_width;
  assign image_height_o = head.image_height;
  assign keep_image_o   = head.keep_image;

endmodule

`default_nettype wire

// ===== test/jfs_size_checker.sv =====
`timescale 1ns / 1ps

module jfs_size_checker import jfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] image_width_i,
  input  logic [15:0] image_height_i,
  input  logic        keep_image_i,
  output int          errors_o,
  output int          pending_o,
  output int          reports_o
);

  localparam logic [7:0] SofFirst = 8'hc0;
  localparam logic [7:0] SofLast  = 8'hcf;
  localparam logic [7:0] MarkDht  = 8'hc4;
  localparam logic [7:0] MarkJpg  = 8'hc8;
  localparam logic [7:0] MarkDac  = 8'hcc;

  // shadow copy of the parser
  phase_e      scan_phase;
  logic [15:0] seg_left;
  logic [2:0]  seg_pos;
  logic [7:0]  len_hi;
  logic [15:0] w_held;
  logic [15:0] h_held;
  logic        size_seen;
  logic        in_sof;
  logic        reported;
  logic        mode_q;

  result_t     size_reports_q[$];
  result_t     exp_r;
  result_t     got_r;
  int          err_cnt;
  int          rep_cnt;

  function automatic logic is_sof(input logic [7:0] m);
    return (m >= SofFirst) && (m <= SofLast) && (m != MarkDht) && (m != MarkJpg) &&
           (m != MarkDac);
  endfunction

  task clear_scan();
    scan_phase = PH_SOI0;
    seg_left   = '0;
    seg_pos    = '0;
    len_hi     = '0;
    w_held     = '0;
    h_held     = '0;
    size_seen  = 1'b0;
    in_sof     = 1'b0;
    reported   = 1'b0;
  endtask

  task emit(input status_e st);
    result_t r;
    r.status       = st;
    r.image_width  = (st == ST_OK) ? w_held : 16'd0;
    r.image_height = (st == ST_OK) ? h_held : 16'd0;
    r.keep_image   = (st == ST_OK) && (mode_q ? (w_held < h_held) : (w_held > h_held));
    size_reports_q.push_back(r);
    reported   = 1'b1;
    scan_phase = PH_DONE;
  endtask

  task scan_byte(input logic [7:0] b, input logic eof);
    logic [15:0] seg_len;
    case (scan_phase)
      PH_SOI0: begin
        if (b != MarkPrefix || eof) emit(ST_NOSOI);
        else scan_phase = PH_SOI1;
      end
      PH_SOI1: begin
        if (b != MarkSoi) emit(ST_NOSOI);
        else scan_phase = PH_HUNT;
      end
      PH_HUNT: begin
        if (b == MarkPrefix) scan_phase = PH_MARK;
      end
      PH_MARK: begin
        // fill bytes keep us in the marker phase
        if (b != MarkPrefix) begin
          if (b == MarkNone || b == MarkTem || (b >= MarkRst0 && b <= MarkSoi)) begin
            scan_phase = PH_HUNT;
          end else if (b == MarkEoi) begin
            if (size_seen) emit(ST_OK);
            else emit(ST_TRUNC);
          end else if (b == MarkSos && size_seen) begin
            emit(ST_OK);
          end else begin
            in_sof     = !size_seen && is_sof(b);
            scan_phase = PH_LENHI;
          end
        end
      end
      PH_LENHI: begin
        len_hi     = b;
        scan_phase = PH_LENLO;
      end
      PH_LENLO: begin
        seg_len = {len_hi, b};
        if (seg_len < MinSegLen || (in_sof && seg_len < MinFrameLen)) begin
          emit(ST_MALFORMED);
        end else begin
          seg_left = seg_len - MinSegLen;
          seg_pos  = '0;
          if (seg_left != 16'd0) scan_phase = PH_BODY;
          else scan_phase = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (in_sof) begin
          // offset 0 is the sample precision
          case (seg_pos)
            3'd1: h_held[15:8] = b;
            3'd2: h_held[7:0]  = b;
            3'd3: w_held[15:8] = b;
            3'd4: begin
              w_held[7:0] = b;
              size_seen   = 1'b1;
              in_sof      = 1'b0;
            end
            default: ;
          endcase
          seg_pos = seg_pos + 3'd1;
        end
        seg_left = seg_left - 16'd1;
        if (seg_left == 16'd0) scan_phase = PH_HUNT;
      end
      default: ;
    endcase
    if (eof) begin
      if (!reported) emit(ST_TRUNC);
      clear_scan();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = 1'b0;
      clear_scan();
      size_reports_q.delete();
      err_cnt = 0;
      rep_cnt = 0;
    end else begin
      // a result beat can never come from this edge's input beat
      if (out_valid_i && out_ready_i) begin
        got_r = {status_i, image_width_i, image_height_i, keep_image_i};
        if (size_reports_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing expected: st=%0d w=%0d h=%0d keep=%0d",
                   $time, status_i, image_width_i, image_height_i, keep_image_i);
        end else begin
          exp_r = size_reports_q.pop_front();
          rep_cnt++;
          if (got_r !== exp_r) begin
            err_cnt++;
            $display("%0t: mismatch, expected st=%0d w=%0d h=%0d keep=%0d,",
                     $time, exp_r.status, exp_r.image_width, exp_r.image_height,
                     exp_r.keep_image);
            $display("%0t:   got st=%0d w=%0d h=%0d keep=%0d",
                     $time, status_i, image_width_i, image_height_i, keep_image_i);
          end
        end
      end
      if (cfg_we_i) mode_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) scan_byte(data_byte_i, end_of_file_i);
    end
    errors_o  <= err_cnt;
    pending_o <= size_reports_q.size();
    reports_o <= rep_cnt;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb import jfs_pkg::*;;

  localparam logic [7:0] SofFirst   = 8'hc0;
  localparam logic [7:0] MarkDht    = 8'hc4;
  localparam logic [7:0] MarkJpg    = 8'hc8;
  localparam logic [7:0] MarkDac    = 8'hcc;
  localparam logic [7:0] SamplePrec = 8'h08;
  localparam int         HoldCycles = 300;
  localparam int         PhaseBytes = 410;
  localparam int         SendIdle [4] = '{0, 47, 0, 9};
  localparam int         RecvIdle [4] = '{0, 0, 47, 9};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_file_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic        keep_image_o;

  int          errors;
  int          pending;
  int          reports;

  int          send_pct = 0;
  int          recv_pct = 0;
  bit          hold_req = 1'b0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          target;
  logic [7:0]  file_q[$];

  jpeg_frame_size_scanner_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .keep_image_o   (keep_image_o)
  );

  jfs_size_checker size_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .image_width_i  (image_width_o),
    .image_height_i (image_height_o),
    .keep_image_i   (keep_image_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .reports_o      (reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  task automatic wait_idle(input int extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    wait_idle(3);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_side();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 16));
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  // markers that carry a length but are never a frame header
  function automatic logic [7:0] pick_other();
    case ($urandom_range(4))
      0: return MarkDht;
      1: return MarkJpg;
      2: return MarkDac;
      3: return 8'($urandom_range(8'h02, 8'hbf));
      default: return 8'($urandom_range(8'hdb, 8'hfe));
    endcase
  endfunction

  task automatic push_segment(input logic [7:0] m, input logic [15:0] len);
    file_q.push_back(MarkPrefix);
    file_q.push_back(m);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    for (int i = 2; i < len; i++) file_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_file();
    int          nseg;
    logic [7:0]  m;
    logic [15:0] len;
    logic [15:0] w;
    logic [15:0] h;
    file_q.delete();
    if ($urandom_range(11) == 0) begin
      repeat ($urandom_range(1, 5)) file_q.push_back(8'($urandom_range(255)));
      return;
    end
    file_q.push_back(MarkPrefix);
    file_q.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : MarkSoi);
    nseg = $urandom_range(0, 4);
    for (int s = 0; s < nseg; s++) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(8'hfe)));
        1: begin
          file_q.push_back(MarkPrefix);
          case ($urandom_range(2))
            0: file_q.push_back(MarkNone);
            1: file_q.push_back(MarkTem);
            default: file_q.push_back(MarkRst0 + 8'($urandom_range(8)));
          endcase
        end
        2: begin
          repeat ($urandom_range(1, 3)) file_q.push_back(MarkPrefix);
          push_segment(pick_other(), MinSegLen);
        end
        3, 4: push_segment(pick_other(), 16'($urandom_range(2, 9)));
        5: push_segment(MarkSos, 16'($urandom_range(2, 6)));
        6, 7: begin
          do m = SofFirst + 8'($urandom_range(15)); while (!is_frame_marker(m));
          len = 16'($urandom_range(7, 11));
          h   = pick_side();
          w   = ($urandom_range(5) == 0) ? h : pick_side();
          file_q.push_back(MarkPrefix);
          file_q.push_back(m);
          file_q.push_back(len[15:8]);
          file_q.push_back(len[7:0]);
          file_q.push_back(SamplePrec);
          file_q.push_back(h[15:8]);
          file_q.push_back(h[7:0]);
          file_q.push_back(w[15:8]);
          file_q.push_back(w[7:0]);
          for (int i = 7; i < len; i++) file_q.push_back(8'($urandom_range(255)));
        end
        8: begin
          // length too short for any segment, or too short for a frame header
          file_q.push_back(MarkPrefix);
          if ($urandom_range(1)) begin
            file_q.push_back(pick_other());
            file_q.push_back(8'h00);
            file_q.push_back(8'($urandom_range(1)));
          end else begin
            do m = SofFirst + 8'($urandom_range(15)); while (!is_frame_marker(m));
            file_q.push_back(m);
            file_q.push_back(8'h00);
            file_q.push_back(8'($urandom_range(2, 6)));
          end
        end
        default: push_segment(pick_other(), 16'($urandom_range(16, 40)));
      endcase
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        file_q.push_back(MarkPrefix);
        file_q.push_back(MarkEoi);
      end
      6, 7: begin
        file_q.push_back(MarkPrefix);
        file_q.push_back(MarkSos);
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom_range(255)));
      end
      8: ;
      default: begin
        // file cut off inside a segment body
        file_q.push_back(MarkPrefix);
        file_q.push_back(pick_other());
        file_q.push_back(8'h00);
        file_q.push_back(8'h20);
        repeat (2) file_q.push_back(8'($urandom_range(255)));
      end
    endcase
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 2)) file_q.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    end_of_file_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed files, orientation mode still at its reset value
    file_q = {MarkNone};
    send_file();
    file_q = {MarkPrefix};
    send_file();
    file_q = {MarkPrefix, 8'h12, 8'h55};
    send_file();
    file_q = {MarkPrefix, MarkSoi, MarkPrefix, MarkEoi};
    send_file();
    file_q = {MarkPrefix, MarkSoi};
    send_file();
    file_q = {MarkPrefix, MarkSoi, MarkPrefix, SofFirst, 8'h00, 8'h07, SamplePrec,
              8'hff, 8'hff, 8'h00, 8'h00, MarkPrefix, MarkEoi};
    send_file();

    for (int p = 0; p < 4; p++) begin
      set_mode(p % 2 == 0);
      send_pct = SendIdle[p];
      recv_pct = RecvIdle[p];
      target   = bytes_sent + PhaseBytes;
      if (p == 0) begin
        // result buffer fills while the receiver holds off
        hold_req = 1'b1;
        repeat (12) begin
          file_q = {MarkNone};
          send_file();
        end
      end
      while (bytes_sent < target) begin
        build_file();
        send_file();
      end
    end

    wait_idle(8);
    $display("tb: %0d bytes in %0d files, %0d size reports checked", bytes_sent,
             files_sent, reports);
    $display("tb: both orientation modes, four idle/stall mixes, one long output hold-off");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
